>>> hw/rtl/fmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmc_pkg
// Shared widths, codes, types and ratio step table of the file migration
// classifier.
// ----------------------------------------------------------------------------
package fmc_pkg;

    // Field widths of one input word and one result word
    localparam int MODE_W    = 2;
    localparam int FILE_ID_W = 48;
    localparam int CHUNK_W   = 24;
    localparam int SIZE_W    = 40;
    localparam int VERDICT_W = 2;
    localparam int SLOT_W    = 10;
    localparam int LEVEL_W   = 4;
    localparam int COUNT_W   = 32;

    // Table depth default for the top level
    localparam int TABLE_DEPTH_DEF = 1024;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 40;
    localparam int THR_W       = 17;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIGRATION_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIG_FILE_BYTES   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD_Q16    = 2'd2;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 17'd52429;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    // Verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_NONE    = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_BELOW   = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_FULL    = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_MIGRATE = 2'd3;

    // Ratio steps 0.60 .. 0.95 in percent
    localparam int RATIO_BINS = 8;
    localparam int BIN_W      = 3;
    localparam int PCT_W      = 7;
    localparam int PCT_SCALE  = 100;
    // shared * 100 and pct * total both fit here
    localparam int PCT_PROD_W = CHUNK_W + PCT_W;

    localparam logic [PCT_W-1:0] STEP_PCT [RATIO_BINS] =
        '{7'd60, 7'd65, 7'd70, 7'd75, 7'd80, 7'd85, 7'd90, 7'd95};

    typedef logic [RATIO_BINS-1:0][COUNT_W-1:0] count_vec_t;

    // Start of a ratio step walk
    typedef struct packed {
        logic               start;
        logic [CHUNK_W-1:0] shared;
        logic [CHUNK_W-1:0] total;
    } ratio_cmd_t;

    // End of a ratio step walk
    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] level;
    } ratio_stat_t;

endpackage

>>> hw/rtl/fmc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmc_in_if
// Request channel: one word is a clear, an append or a query.
// ----------------------------------------------------------------------------
interface fmc_in_if;
    import fmc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [FILE_ID_W-1:0] file_id;
    logic [CHUNK_W-1:0]   chunk_count;
    logic [SIZE_W-1:0]    file_size;

    modport source (
        output valid,
        output mode,
        output file_id,
        output chunk_count,
        output file_size,
        input  ready
    );

    modport sink (
        input  valid,
        input  mode,
        input  file_id,
        input  chunk_count,
        input  file_size,
        output ready
    );
endinterface

>>> hw/rtl/fmc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmc_out_if
// Result channel: verdict, lookup fields and the eight ratio counters.
// ----------------------------------------------------------------------------
interface fmc_out_if;
    import fmc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [VERDICT_W-1:0] verdict;
    logic [CHUNK_W-1:0]   total_chunks;
    logic [SLOT_W-1:0]    file_slot;
    logic [LEVEL_W-1:0]   ratio_level;
    logic [COUNT_W-1:0]   count_060;
    logic [COUNT_W-1:0]   count_065;
    logic [COUNT_W-1:0]   count_070;
    logic [COUNT_W-1:0]   count_075;
    logic [COUNT_W-1:0]   count_080;
    logic [COUNT_W-1:0]   count_085;
    logic [COUNT_W-1:0]   count_090;
    logic [COUNT_W-1:0]   count_095;

    modport source (
        output valid,
        output verdict,
        output total_chunks,
        output file_slot,
        output ratio_level,
        output count_060,
        output count_065,
        output count_070,
        output count_075,
        output count_080,
        output count_085,
        output count_090,
        output count_095,
        input  ready
    );

    modport sink (
        input  valid,
        input  verdict,
        input  total_chunks,
        input  file_slot,
        input  ratio_level,
        input  count_060,
        input  count_065,
        input  count_070,
        input  count_075,
        input  count_080,
        input  count_085,
        input  count_090,
        input  count_095,
        output ready
    );
endinterface

>>> hw/rtl/fmc_ratio_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmc_ratio_bank
// Ratio step counters. Walks the steps 0.60 .. 0.95 one per cycle, raises
// the counter of each step met and stops at the first step missed.
// ----------------------------------------------------------------------------
module fmc_ratio_bank (
    input  logic                clk,
    input  logic                rst_n,
    input  fmc_pkg::ratio_cmd_t cmd,
    output fmc_pkg::ratio_stat_t stat,
    output fmc_pkg::count_vec_t counts
);
    import fmc_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [BIN_W-1:0]      bin_reg;
    logic [LEVEL_W-1:0]    level_reg;
    logic [PCT_PROD_W-1:0] shared_x100_reg;
    logic [CHUNK_W-1:0]    total_reg;
    count_vec_t            cnt_reg;

    logic [PCT_PROD_W-1:0] step_rhs;
    logic                  step_met;

    // Compare shared*100 against pct*total for the current step
    assign step_rhs = PCT_PROD_W'(STEP_PCT[bin_reg]) * PCT_PROD_W'(total_reg);
    assign step_met = (shared_x100_reg >= step_rhs);

    // Control and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            bin_reg   <= '0;
            level_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg  <= 1'b1;
                bin_reg   <= '0;
                level_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_met)
                begin
                    cnt_reg[bin_reg] <= cnt_reg[bin_reg] + COUNT_W'(1);
                    level_reg        <= level_reg + LEVEL_W'(1);
                    if (bin_reg == BIN_W'(RATIO_BINS - 1))
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        bin_reg <= bin_reg + BIN_W'(1);
                    end
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Capture operands at start
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            shared_x100_reg <= PCT_PROD_W'(cmd.shared) * PCT_PROD_W'(PCT_SCALE);
            total_reg       <= cmd.total;
        end
    end

    assign stat.done  = done_reg;
    assign stat.level = level_reg;
    assign counts     = cnt_reg;

endmodule

>>> hw/rtl/file_migration_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_migration_classifier_unit
// File record table with binary-search lookup and migration classification.
// ----------------------------------------------------------------------------
// The block takes one request word at a time and gives one result word for
// each. Clear, append and the unused mode go from acceptance through the
// DONE state to the output register. A query makes one table probe per
// search step, each a read of the record memory's registered read port
// (SEARCH) followed by the id compare (PROBE); a table of N records needs
// at most ceil(log2(N+1)) probes, 11 for 1024. A query that misses ends
// when SEARCH finds its search window empty. A found file then passes the
// threshold multiply (MATCH) and the decision (DECIDE), and a migration
// then waits in RATIO for the ratio step walk, one step per cycle, before
// DONE. The next request is taken as soon as the result is in the output
// register, while that result still waits; a finished word stalls until
// the previous one has been taken.
// The record memory has no reset; entries past the fill count are never read.
// ----------------------------------------------------------------------------
module file_migration_classifier_unit #(
    parameter int TABLE_DEPTH = fmc_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fmc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fmc_pkg::CFG_DATA_W-1:0]      cfg_data,
    fmc_in_if.sink                              request,
    fmc_out_if.source                           result
);
    import fmc_pkg::*;

    localparam int ADDR_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FILL_W     = $clog2(TABLE_DEPTH + 1);
    localparam int REC_W      = FILE_ID_W + CHUNK_W + SIZE_W;
    localparam int SLOT_PAD_W = (ADDR_W > SLOT_W) ? ADDR_W : SLOT_W;
    localparam int THR_PROD_W = THR_W + CHUNK_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_PROBE  = 3'd2;
    localparam logic [2:0] S_MATCH  = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_RATIO  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    // Configuration
    logic               en_reg;
    logic [SIZE_W-1:0]  big_reg;
    logic [THR_W-1:0]   thr_reg;

    // Sequencer and search window (hi is exclusive)
    logic [2:0]         state_reg, state_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [FILL_W-1:0]  lo_reg, lo_next;
    logic [FILL_W-1:0]  hi_reg, hi_next;
    logic [ADDR_W-1:0]  mid_reg, mid_next;

    // Query operands and found record
    logic [FILE_ID_W-1:0]  qid_reg, qid_next;
    logic [CHUNK_W-1:0]    shared_reg, shared_next;
    logic [CHUNK_W-1:0]    total_reg, total_next;
    logic                  size_ok_reg, size_ok_next;
    logic                  equal_reg, equal_next;
    logic [THR_PROD_W-1:0] thr_prod_reg, thr_prod_next;

    // Result under construction
    logic [VERDICT_W-1:0] res_verdict_reg, res_verdict_next;
    logic [CHUNK_W-1:0]   res_total_reg, res_total_next;
    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic [LEVEL_W-1:0]   res_level_reg, res_level_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic                 out_load;
    logic [VERDICT_W-1:0] out_verdict_reg;
    logic [CHUNK_W-1:0]   out_total_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic [LEVEL_W-1:0]   out_level_reg;
    count_vec_t           out_cnt_reg;

    // Record memory
    logic [REC_W-1:0]     rec_mem [TABLE_DEPTH];
    logic [REC_W-1:0]     rd_data_reg;
    logic                 mem_we;
    logic                 mem_re;
    logic [ADDR_W-1:0]    wr_addr;
    logic [REC_W-1:0]     wr_data;

    logic [FILE_ID_W-1:0] rd_id;
    logic [CHUNK_W-1:0]   rd_chunks;
    logic [SIZE_W-1:0]    rd_size;

    logic [FILL_W:0]      mid_sum;
    logic [ADDR_W-1:0]    mid_calc;
    logic [SLOT_PAD_W-1:0] mid_pad;
    logic                 accept;

    ratio_cmd_t           rcmd;
    ratio_stat_t          rstat;
    count_vec_t           counts;

    assign accept = request.valid && request.ready;
    assign request.ready = (state_reg == S_IDLE);

    assign rd_id     = rd_data_reg[REC_W-1 -: FILE_ID_W];
    assign rd_chunks = rd_data_reg[SIZE_W +: CHUNK_W];
    assign rd_size   = rd_data_reg[SIZE_W-1:0];

    // Midpoint of [lo, hi-1]; hi > lo whenever it is used
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg} - (FILL_W + 1)'(1);
    assign mid_calc = mid_sum[ADDR_W:1];
    assign mid_pad  = SLOT_PAD_W'(mid_reg);

    // Record write on append
    assign wr_addr = fill_reg[ADDR_W-1:0];
    assign wr_data = {request.file_id, request.chunk_count, request.file_size};

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        mid_next         = mid_reg;
        qid_next         = qid_reg;
        shared_next      = shared_reg;
        total_next       = total_reg;
        size_ok_next     = size_ok_reg;
        equal_next       = equal_reg;
        thr_prod_next    = thr_prod_reg;
        res_verdict_next = res_verdict_reg;
        res_total_next   = res_total_reg;
        res_slot_next    = res_slot_reg;
        res_level_next   = res_level_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        out_load         = 1'b0;
        rcmd.start       = 1'b0;
        rcmd.shared      = shared_reg;
        rcmd.total       = total_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_verdict_next = VERDICT_NONE;
                    res_total_next   = '0;
                    res_slot_next    = '0;
                    res_level_next   = '0;
                    qid_next         = request.file_id;
                    shared_next      = request.chunk_count;
                    lo_next          = '0;
                    hi_next          = fill_reg;
                    state_next       = S_DONE;
                    case (request.mode)
                        MODE_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        MODE_APPEND:
                        begin
                            if (fill_reg < FILL_W'(TABLE_DEPTH))
                            begin
                                mem_we    = 1'b1;
                                fill_next = fill_reg + FILL_W'(1);
                            end
                        end
                        MODE_QUERY:
                        begin
                            state_next = S_SEARCH;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                // Issue a probe or give up on an empty window
                if (lo_reg < hi_reg)
                begin
                    mem_re     = 1'b1;
                    mid_next   = mid_calc;
                    state_next = S_PROBE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_PROBE:
            begin
                if (rd_id == qid_reg)
                begin
                    total_next     = rd_chunks;
                    size_ok_next   = (rd_size >= big_reg);
                    equal_next     = (rd_chunks == shared_reg);
                    res_total_next = rd_chunks;
                    res_slot_next  = mid_pad[SLOT_W-1:0];
                    state_next     = S_MATCH;
                end
                else if (rd_id < qid_reg)
                begin
                    lo_next    = FILL_W'(mid_reg) + FILL_W'(1);
                    state_next = S_SEARCH;
                end
                else
                begin
                    hi_next    = FILL_W'(mid_reg);
                    state_next = S_SEARCH;
                end
            end
            S_MATCH:
            begin
                thr_prod_next = THR_PROD_W'(thr_reg) * THR_PROD_W'(total_reg);
                state_next    = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (equal_reg)
                begin
                    res_verdict_next = VERDICT_FULL;
                    state_next       = S_DONE;
                end
                else if (en_reg && size_ok_reg &&
                         (THR_PROD_W'({shared_reg, 16'd0}) >= thr_prod_reg))
                begin
                    res_verdict_next = VERDICT_MIGRATE;
                    rcmd.start       = 1'b1;
                    state_next       = S_RATIO;
                end
                else
                begin
                    res_verdict_next = VERDICT_BELOW;
                    state_next       = S_DONE;
                end
            end
            S_RATIO:
            begin
                if (rstat.done)
                begin
                    res_level_next = rstat.level;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hand the word to the output register once it is free
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop once taken
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            en_reg        <= 1'b1;
            big_reg       <= '0;
            thr_reg       <= THRESHOLD_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MIGRATION_ENABLE: en_reg  <= cfg_data[0];
                    CFG_BIG_FILE_BYTES:   big_reg <= cfg_data[SIZE_W-1:0];
                    CFG_THRESHOLD_Q16:    thr_reg <= cfg_data[THR_W-1:0];
                    default:              ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        mid_reg         <= mid_next;
        qid_reg         <= qid_next;
        shared_reg      <= shared_next;
        total_reg       <= total_next;
        size_ok_reg     <= size_ok_next;
        equal_reg       <= equal_next;
        thr_prod_reg    <= thr_prod_next;
        res_verdict_reg <= res_verdict_next;
        res_total_reg   <= res_total_next;
        res_slot_reg    <= res_slot_next;
        res_level_reg   <= res_level_next;
        if (out_load)
        begin
            out_verdict_reg <= res_verdict_reg;
            out_total_reg   <= res_total_reg;
            out_slot_reg    <= res_slot_reg;
            out_level_reg   <= res_level_reg;
            out_cnt_reg     <= counts;
        end
    end

    // Record memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rec_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= rec_mem[mid_calc];
        end
    end

    fmc_ratio_bank u_ratio_bank (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (rcmd),
        .stat   (rstat),
        .counts (counts)
    );

    // Drive the result channel
    assign result.valid        = out_valid_reg;
    assign result.verdict      = out_verdict_reg;
    assign result.total_chunks = out_total_reg;
    assign result.file_slot    = out_slot_reg;
    assign result.ratio_level  = out_level_reg;
    assign result.count_060    = out_cnt_reg[0];
    assign result.count_065    = out_cnt_reg[1];
    assign result.count_070    = out_cnt_reg[2];
    assign result.count_075    = out_cnt_reg[3];
    assign result.count_080    = out_cnt_reg[4];
    assign result.count_085    = out_cnt_reg[5];
    assign result.count_090    = out_cnt_reg[6];
    assign result.count_095    = out_cnt_reg[7];

endmodule
